>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk while rst_n is high
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/mplm_pkg.sv
`timescale 1ns / 1ps

package mplm_pkg;

  typedef enum logic [1:0] {
    REQ_TEXT     = 2'd0,
    REQ_PAT_BYTE = 2'd1,
    REQ_PAT_LEN  = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_PATTERN_COUNT = 2'd0,
    CFG_FOLD_CASE     = 2'd1,
    CFG_ANY_MODE      = 2'd2
  } cfg_reg_t;

  localparam int REQ_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int SLOT_W     = 3;
  localparam int POS_W      = 5;
  localparam int PLEN_W     = 6;
  localparam int LINE_NUM_W = 24;
  localparam int COUNT_W    = 4;

  localparam int IN_USER_W  = REQ_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [BYTE_W-1:0]     LF_BYTE      = 8'h0A;
  localparam logic [LINE_NUM_W-1:0] LINE_NUM_MAX = 24'hFFFFFF;

  // per-lane controls for one processed item
  typedef struct packed {
    logic track;
    logic clear;
    logic wr_byte;
    logic wr_len;
    logic fold;
  } lane_ctrl_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                  input logic en);
    logic upper;
    upper = (c >= 8'h41) && (c <= 8'h5A);
    return (en && upper) ? c + 8'h20 : c;
  endfunction

endpackage

>>> rtl/mplm_lane.sv
`timescale 1ns / 1ps

module mplm_lane #(
  parameter int PATTERN_MAX_LEN = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mplm_pkg::lane_ctrl_t        ctrl,
  input  logic [mplm_pkg::BYTE_W-1:0] data_byte,
  input  logic [mplm_pkg::POS_W-1:0]  char_position,
  input  logic [mplm_pkg::PLEN_W-1:0] pattern_length,
  output logic                        hit
);
  import mplm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX_LEN + 1);
  localparam int IDX_W = (PATTERN_MAX_LEN > 1) ? $clog2(PATTERN_MAX_LEN) : 1;
  localparam int CMP_W = 7;

  logic [BYTE_W-1:0]          store_r [PATTERN_MAX_LEN];
  logic [LEN_W-1:0]           len_r;
  logic [LEN_W-1:0]           len_nxt;
  logic [PATTERN_MAX_LEN-1:0] bits_r;
  logic [PATTERN_MAX_LEN-1:0] bits_nxt;
  logic                       seen_r;
  logic                       seen_nxt;

  logic [BYTE_W-1:0]          text_c;
  logic [PATTERN_MAX_LEN-1:0] eq;
  logic [PATTERN_MAX_LEN:0]   shifted;
  logic [PATTERN_MAX_LEN-1:0] d;
  logic                       hit_now;

  // shift-and step over all pattern positions at once
  always_comb begin
    text_c  = fold_byte(data_byte, ctrl.fold);
    shifted = {bits_r, 1'b1};
    hit_now = 1'b0;
    for (int j = 0; j < PATTERN_MAX_LEN; j++) begin
      eq[j] = (LEN_W'(j) < len_r) && (fold_byte(store_r[j], ctrl.fold) == text_c);
    end
    d = shifted[PATTERN_MAX_LEN-1:0] & eq;
    for (int j = 0; j < PATTERN_MAX_LEN; j++) begin
      if (d[j] && (len_r == LEN_W'(j + 1))) hit_now = 1'b1;
    end
  end

  assign hit = (len_r == '0) || seen_r || (ctrl.track && hit_now);

  always_comb begin
    len_nxt  = len_r;
    bits_nxt = bits_r;
    seen_nxt = seen_r;
    if (ctrl.wr_len) begin
      if (CMP_W'(pattern_length) > CMP_W'(PATTERN_MAX_LEN)) begin
        len_nxt = LEN_W'(PATTERN_MAX_LEN);
      end else begin
        len_nxt = LEN_W'(pattern_length);
      end
    end
    if (ctrl.clear) begin
      bits_nxt = '0;
      seen_nxt = 1'b0;
    end else if (ctrl.track) begin
      bits_nxt = d;
      seen_nxt = seen_r || hit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      bits_r <= '0;
      seen_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      bits_r <= bits_nxt;
      seen_r <= seen_nxt;
    end
  end

  // pattern bytes hold no reset value
  always_ff @(posedge clk) begin
    if (ctrl.wr_byte && (CMP_W'(char_position) < CMP_W'(PATTERN_MAX_LEN))) begin
      store_r[IDX_W'(char_position)] <= data_byte;
    end
  end

endmodule

>>> rtl/multi_pattern_line_matcher.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Streaming line matcher: text bytes are tested against up to NUM_PATTERNS
// stored substring patterns, one item per clock sustained. An accepted item
// sits in an input register while every pattern lane updates its shift-and
// bits in parallel, and a finished line lands in the output register, so a
// result is offered once its line-ending byte has passed both registers.
// The input side only waits when a line-ending byte meets
// a full output register that is not being taken; load items and bytes
// within a line always pass. Pattern bytes and lengths arrive as load items
// on the same stream (in_tuser selects the kind); the number of patterns in
// use, case folding and the any/all mode are written on the cfg channel, by
// the user only while the stream is idle; the block does not enforce this.
module multi_pattern_line_matcher #(
  parameter int NUM_PATTERNS     = 8,
  parameter int PATTERN_MAX_LEN  = 32,
  parameter int LINE_BUFFER_SIZE = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] data_byte, [10:8] pattern_slot, [15:11] char_position,
  // [21:16] pattern_length, [23:22] zero
  input  logic [mplm_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [mplm_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] line_matched, [24:1] line_no, [25] file_found, [31:26] zero
  output logic [mplm_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mplm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mplm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mplm_pkg::*;

  localparam int CHUNK_W = (LINE_BUFFER_SIZE > 2) ? $clog2(LINE_BUFFER_SIZE) : 1;
  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(LINE_BUFFER_SIZE - 2);
  localparam int NCMP_W = 5;
  localparam int PAD_W  = OUT_DATA_W - LINE_NUM_W - 2;

  // configuration
  logic [COUNT_W-1:0] pat_cnt_r;
  logic               fold_case_r;
  logic               any_mode_r;

  // input register
  logic               in_vld_r;
  logic [REQ_W-1:0]   item_req_r;
  logic [BYTE_W-1:0]  item_byte_r;
  logic [SLOT_W-1:0]  item_slot_r;
  logic [POS_W-1:0]   item_pos_r;
  logic [PLEN_W-1:0]  item_len_r;
  logic               item_eof_r;

  // line state
  logic [CHUNK_W-1:0]    chunk_r;
  logic [CHUNK_W-1:0]    chunk_nxt;
  logic [LINE_NUM_W-1:0] line_cnt_r;
  logic [LINE_NUM_W-1:0] line_cnt_nxt;
  logic                  file_any_r;
  logic                  file_any_nxt;

  // output register
  logic                  out_vld_r;
  logic                  out_matched_r;
  logic [LINE_NUM_W-1:0] out_num_r;
  logic                  out_done_r;
  logic                  out_found_r;

  logic                    is_text;
  logic                    is_pat_byte;
  logic                    is_pat_len;
  logic                    ends_line;
  logic                    out_free;
  logic                    fire;
  logic [NCMP_W-1:0]       active_n;
  logic [NUM_PATTERNS-1:0] in_use;
  logic [NUM_PATTERNS-1:0] lane_hit;
  logic                    line_match;
  logic [LINE_NUM_W-1:0]   line_num;

  always_comb begin
    is_text     = 1'b0;
    is_pat_byte = 1'b0;
    is_pat_len  = 1'b0;
    case (req_type_t'(item_req_r))
      REQ_TEXT:     is_text     = in_vld_r;
      REQ_PAT_BYTE: is_pat_byte = in_vld_r;
      REQ_PAT_LEN:  is_pat_len  = in_vld_r;
      default:      ;
    endcase
  end

  // a line closes on newline, a full chunk or end of file
  assign ends_line = is_text &&
                     ((item_byte_r == LF_BYTE) || (chunk_r == CHUNK_LAST) || item_eof_r);
  assign out_free  = !out_vld_r || out_tready;
  assign fire      = in_vld_r && (!ends_line || out_free);
  assign in_tready = !in_vld_r || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_req_r  <= in_tuser[REQ_W-1:0];
      item_byte_r <= in_tdata[7:0];
      item_slot_r <= in_tdata[10:8];
      item_pos_r  <= in_tdata[15:11];
      item_len_r  <= in_tdata[21:16];
      item_eof_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_cnt_r   <= '0;
      fold_case_r <= 1'b0;
      any_mode_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_COUNT: pat_cnt_r   <= cfg_data[COUNT_W-1:0];
        CFG_FOLD_CASE:     fold_case_r <= cfg_data[0];
        CFG_ANY_MODE:      any_mode_r  <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_lane
    lane_ctrl_t lane_ctrl;
    logic       slot_sel;

    assign slot_sel          = (NCMP_W'(item_slot_r) == NCMP_W'(p));
    assign lane_ctrl.track   = fire && is_text;
    assign lane_ctrl.clear   = fire && ends_line;
    assign lane_ctrl.wr_byte = fire && is_pat_byte && slot_sel;
    assign lane_ctrl.wr_len  = fire && is_pat_len && slot_sel;
    assign lane_ctrl.fold    = fold_case_r;

    mplm_lane #(
      .PATTERN_MAX_LEN(PATTERN_MAX_LEN)
    ) u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (lane_ctrl),
      .data_byte     (item_byte_r),
      .char_position (item_pos_r),
      .pattern_length(item_len_r),
      .hit           (lane_hit[p])
    );
  end

  // combine lane hits over the slots in use
  always_comb begin
    if (NCMP_W'(pat_cnt_r) > NCMP_W'(NUM_PATTERNS)) begin
      active_n = NCMP_W'(NUM_PATTERNS);
    end else begin
      active_n = NCMP_W'(pat_cnt_r);
    end
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      in_use[p] = NCMP_W'(p) < active_n;
    end
    if (any_mode_r) begin
      line_match = |(lane_hit & in_use);
    end else begin
      line_match = &(lane_hit | ~in_use);
    end
    line_num = (line_cnt_r == LINE_NUM_MAX) ? line_cnt_r : line_cnt_r + 1'b1;
  end

  always_comb begin
    chunk_nxt    = chunk_r;
    line_cnt_nxt = line_cnt_r;
    file_any_nxt = file_any_r;
    if (fire && is_text) begin
      chunk_nxt = ends_line ? '0 : chunk_r + 1'b1;
    end
    if (fire && ends_line) begin
      line_cnt_nxt = item_eof_r ? '0 : line_num;
      file_any_nxt = !item_eof_r && (file_any_r || line_match);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r    <= '0;
      line_cnt_r <= '0;
      file_any_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      chunk_r    <= chunk_nxt;
      line_cnt_r <= line_cnt_nxt;
      file_any_r <= file_any_nxt;
      if (fire && ends_line) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ends_line) begin
      out_matched_r <= line_match;
      out_num_r     <= line_num;
      out_done_r    <= item_eof_r;
      out_found_r   <= item_eof_r && (file_any_r || line_match);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_done_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_found_r, out_num_r, out_matched_r};

  `ASSERT_IMPL(a_found_only_at_eof, out_vld_r && !out_done_r, !out_found_r)
  `ASSERT_IMPL(a_line_num_nonzero, out_vld_r, out_num_r != '0)
  `ASSERT_IMPL(a_chunk_bound, 1'b1, chunk_r <= CHUNK_LAST)
  `ASSERT_NEXT(a_eof_clears_count, fire && ends_line && item_eof_r,
               line_cnt_r == '0 && !file_any_r)

endmodule
